@@ hdl/bwmf_pkg.sv @@
// Package of the binary weighted majority filter: sizes, types, config codes
// and the 5x5 vote weight table.
// No dependencies; bwmf_row_seq, bwmf_vote and the top level import it.
package bwmf_pkg;

  localparam int unsigned MaxCols   = 64;
  localparam int unsigned MaxRows   = 64;
  localparam int unsigned Taps      = 5;
  localparam int unsigned HistRows  = 4;
  localparam int unsigned HistDepth = 1;
  localparam int unsigned HistAddrW = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int unsigned CntW      = 6;
  localparam int unsigned DimW      = 7;
  localparam int unsigned ThrW      = 9;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 9;
  localparam int unsigned PartW     = 17;
  localparam int unsigned SumW      = 18;
  localparam int unsigned ProdW     = ThrW + SumW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHeight    = 2'd0,
    CfgWidth     = 2'd1,
    CfgThreshold = 2'd2
  } bwmf_cfg_e;

  typedef logic [MaxCols-1:0] bwmf_row_t;
  typedef bwmf_row_t [HistRows-1:0] bwmf_hist_t;
  typedef bwmf_row_t [Taps-1:0] bwmf_win_t;
  typedef logic [PartW-1:0] bwmf_part_t;

  typedef struct packed {
    bwmf_win_t         rows;
    logic [Taps-1:0]   present;
    logic [CntW-1:0]   row_num;
    logic              done;
  } bwmf_job_t;

  localparam bwmf_part_t VoteWeight [Taps][Taps] = '{
    '{17'd22,   17'd442,   17'd1200,  17'd442,   17'd22},
    '{17'd442,  17'd8869,  17'd24109, 17'd24109, 17'd442},
    '{17'd1200, 17'd24109, 17'd65536, 17'd24109, 17'd1200},
    '{17'd442,  17'd24109, 17'd24109, 17'd8869,  17'd442},
    '{17'd22,   17'd442,   17'd1200,  17'd442,   17'd22}
  };

endpackage

@@ hdl/bwmf_ram.sv @@
// Generic synchronous RAM with one write port and one registered read port.
// Stand-alone; no package dependency.
module bwmf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [2**AddrW];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/bwmf_row_seq.sv @@
// Row intake: row counter, row history kept in a RAM with write forwarding,
// and a sequencer that issues one vote job per output row.
// Depends on bwmf_pkg and bwmf_ram.
module bwmf_row_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bwmf_pkg::bwmf_row_t        row_pixels_i,
  input  logic [bwmf_pkg::DimW-1:0]  height_i,
  input  bwmf_pkg::bwmf_row_t        col_mask_i,
  output logic                       job_valid_o,
  output bwmf_pkg::bwmf_job_t        job_o,
  input  logic                       job_ready_i
);
  import bwmf_pkg::*;

  logic            accept;
  logic            last_in;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic            a_vld_q, a_fwd_q, a_last_q;
  bwmf_row_t       a_cur_q;
  logic [CntW-1:0] a_r_q;
  logic            a_go, a_jobs;

  bwmf_hist_t      hist_rd, hist_cur, hist_new, hist_fwd_q;
  logic            hist_vld_q;

  logic            b_vld_q, b_last_q, b_more, b_free;
  bwmf_win_t       b_win_q, win_load;
  logic [CntW-1:0] b_r_q, b_c_q, c_load, off_full;
  logic [1:0]      off;
  logic [2:0]      idx;

  assign accept  = in_valid_i && !in_stall_o;
  assign last_in = ({1'b0, cnt_q} + DimW'(1)) >= height_i;
  assign cnt_d   = last_in ? '0 : cnt_q + CntW'(1);

  assign b_more     = b_last_q && (b_c_q != b_r_q);
  assign b_free     = !b_vld_q || (job_ready_i && !b_more);
  assign a_go       = a_vld_q && b_free;
  assign a_jobs     = a_last_q || (a_r_q >= CntW'(2));
  assign in_stall_o = a_vld_q && !b_free;

  bwmf_ram #(
    .Width ($bits(bwmf_hist_t)),
    .Depth (HistDepth)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (a_go),
    .waddr_i ({HistAddrW{1'b0}}),
    .wdata_i (hist_new),
    .re_i    (accept),
    .raddr_i ({HistAddrW{1'b0}}),
    .rdata_o (hist_rd)
  );

  always_comb begin
    if (a_fwd_q) begin
      hist_cur = hist_fwd_q;
    end else if (hist_vld_q) begin
      hist_cur = hist_rd;
    end else begin
      hist_cur = '0;
    end
    hist_new[0] = a_cur_q;
    for (int i = 1; i < HistRows; i++) begin
      hist_new[i] = hist_cur[i-1];
    end
    if (a_last_q) begin
      hist_new = '0;
    end
    for (int j = 0; j < HistRows; j++) begin
      win_load[j] = hist_cur[HistRows-1-j] & col_mask_i;
    end
    win_load[Taps-1] = a_cur_q;
    c_load = (a_r_q >= CntW'(2)) ? a_r_q - CntW'(2) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      a_vld_q    <= 1'b0;
      a_fwd_q    <= 1'b0;
      hist_vld_q <= 1'b0;
      b_vld_q    <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q   <= cnt_d;
        a_vld_q <= 1'b1;
        a_fwd_q <= a_go;
      end else if (a_go) begin
        a_vld_q <= 1'b0;
      end
      if (a_go) begin
        hist_vld_q <= 1'b1;
      end
      if (a_go && a_jobs) begin
        b_vld_q <= 1'b1;
      end else if (b_vld_q && job_ready_i && !b_more) begin
        b_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_cur_q  <= row_pixels_i & col_mask_i;
      a_r_q    <= cnt_q;
      a_last_q <= last_in;
    end
    if (a_go) begin
      hist_fwd_q <= hist_new;
    end
    if (a_go && a_jobs) begin
      b_win_q  <= win_load;
      b_r_q    <= a_r_q;
      b_c_q    <= c_load;
      b_last_q <= a_last_q;
    end else if (b_vld_q && job_ready_i && b_more) begin
      b_c_q <= b_c_q + CntW'(1);
    end
  end

  // The job window covers rows c-2 .. c+2; b_win_q holds rows r-4 .. r.
  assign off_full = b_c_q + CntW'(2) - b_r_q;
  assign off      = off_full[1:0];

  always_comb begin
    job_o.row_num = b_c_q;
    job_o.done    = b_last_q && (b_c_q == b_r_q);
    idx           = '0;
    for (int k = 0; k < Taps; k++) begin
      idx = {1'b0, off} + 3'(k);
      if (idx <= 3'(Taps - 1)) begin
        job_o.rows[k]    = b_win_q[idx];
        job_o.present[k] = ({1'b0, b_c_q} + DimW'(k)) >= DimW'(2);
      end else begin
        job_o.rows[k]    = '0;
        job_o.present[k] = 1'b0;
      end
    end
  end

  assign job_valid_o = b_vld_q;

endmodule

@@ hdl/bwmf_vote.sv @@
// Vote pipeline over 64 column lanes: per-row partial sums, 5x5 sums,
// threshold product and final compare into the output register.
// Depends on bwmf_pkg.
module bwmf_vote (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  input  bwmf_pkg::bwmf_job_t        job_i,
  output logic                       job_ready_o,
  input  bwmf_pkg::bwmf_row_t        col_mask_i,
  input  logic [bwmf_pkg::ThrW-1:0]  thr_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bwmf_pkg::bwmf_row_t        filtered_row_o,
  output logic [bwmf_pkg::CntW-1:0]  row_number_o,
  output logic                       frame_done_o
);
  import bwmf_pkg::*;

  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  logic [MaxCols+3:0] ext_mask;
  logic [MaxCols+3:0] ext_row [Taps];

  bwmf_part_t p_blk_d [MaxCols][Taps];
  bwmf_part_t p_tot_d [MaxCols][Taps];
  bwmf_part_t s1_blk_q [MaxCols][Taps];
  bwmf_part_t s1_tot_q [MaxCols][Taps];

  logic [SumW-1:0] s_blk_d [MaxCols];
  logic [SumW-1:0] s_tot_d [MaxCols];
  logic [SumW-1:0] s2_blk_q [MaxCols];
  logic [SumW-1:0] s2_tot_q [MaxCols];

  logic [SumW-1:0]  s3_blk_q [MaxCols];
  logic [ProdW-1:0] s3_prod_q [MaxCols];

  bwmf_row_t       pass_d;
  logic [CntW-1:0] s1_num_q, s2_num_q, s3_num_q;
  logic            s1_done_q, s2_done_q, s3_done_q;

  bwmf_row_t       out_row_q;
  logic [CntW-1:0] out_num_q;
  logic            out_done_q;

  assign en4         = !v4_q || !out_stall_i;
  assign en3         = !v3_q || en4;
  assign en2         = !v2_q || en3;
  assign en1         = !v1_q || en2;
  assign job_ready_o = en1;

  always_comb begin
    ext_mask = {2'b00, col_mask_i, 2'b00};
    for (int k = 0; k < Taps; k++) begin
      ext_row[k] = {2'b00, job_i.rows[k], 2'b00};
    end
    for (int c = 0; c < MaxCols; c++) begin
      for (int k = 0; k < Taps; k++) begin
        p_blk_d[c][k] = '0;
        p_tot_d[c][k] = '0;
        for (int d = 0; d < Taps; d++) begin
          if (job_i.present[k] && ext_mask[c+d]) begin
            p_tot_d[c][k] = p_tot_d[c][k] + VoteWeight[k][d];
            if (ext_row[k][c+d]) begin
              p_blk_d[c][k] = p_blk_d[c][k] + VoteWeight[k][d];
            end
          end
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < MaxCols; c++) begin
      s_blk_d[c] = '0;
      s_tot_d[c] = '0;
      for (int k = 0; k < Taps; k++) begin
        s_blk_d[c] = s_blk_d[c] + SumW'(s1_blk_q[c][k]);
        s_tot_d[c] = s_tot_d[c] + SumW'(s1_tot_q[c][k]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < MaxCols; c++) begin
      pass_d[c] = col_mask_i[c] && (ProdW'({s3_blk_q[c], 8'b0}) >= s3_prod_q[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= job_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_blk_q  <= p_blk_d;
      s1_tot_q  <= p_tot_d;
      s1_num_q  <= job_i.row_num;
      s1_done_q <= job_i.done;
    end
    if (en2) begin
      s2_blk_q  <= s_blk_d;
      s2_tot_q  <= s_tot_d;
      s2_num_q  <= s1_num_q;
      s2_done_q <= s1_done_q;
    end
    if (en3) begin
      for (int c = 0; c < MaxCols; c++) begin
        s3_blk_q[c]  <= s2_blk_q[c];
        s3_prod_q[c] <= ProdW'(thr_i) * ProdW'(s2_tot_q[c]);
      end
      s3_num_q  <= s2_num_q;
      s3_done_q <= s2_done_q;
    end
    if (en4) begin
      out_row_q  <= pass_d;
      out_num_q  <= s3_num_q;
      out_done_q <= s3_done_q;
    end
  end

  assign out_valid_o    = v4_q;
  assign filtered_row_o = out_row_q;
  assign row_number_o   = out_num_q;
  assign frame_done_o   = out_done_q;

endmodule

@@ hdl/binary_weighted_majority_filter_top.sv @@
// Top level of the binary weighted majority filter: configuration registers
// and the connection of row intake and vote pipeline.
// Depends on bwmf_pkg, bwmf_row_seq and bwmf_vote.

// The block takes one 64-pixel binary row per cycle when not stalled and,
// from the third row of a frame on, returns the 5x5 weighted-vote result
// for the row two above it through the intake, job, vote and output
// registers. The last row of a frame flushes the remaining rows: the row
// sequencer issues one output row per cycle while the vote pipeline takes
// jobs, so that row holds the input until they are issued. Row history
// lives in a RAM that is read when a row is taken and written one stage
// later, with forwarding between consecutive rows. Configuration writes
// are taken in every cycle and must only be made while no row is in flight.
module binary_weighted_majority_filter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bwmf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bwmf_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bwmf_pkg::MaxCols-1:0]   row_pixels_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bwmf_pkg::MaxCols-1:0]   filtered_row_o,
  output logic [bwmf_pkg::CntW-1:0]      row_number_o,
  output logic                           frame_done_o
);
  import bwmf_pkg::*;

  logic [DimW-1:0] height_q, width_q;
  logic [ThrW-1:0] thr_q;
  logic [DimW-1:0] height_eff, width_eff;
  bwmf_row_t       col_mask;
  bwmf_cfg_e       cfg_sel;

  logic            job_valid, job_ready;
  bwmf_job_t       job;

  assign cfg_ready_o = 1'b1;
  assign cfg_sel     = bwmf_cfg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= DimW'(MaxRows);
      width_q  <= DimW'(MaxCols);
      thr_q    <= ThrW'(128);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_sel)
        CfgHeight:    height_q <= cfg_data_i[DimW-1:0];
        CfgWidth:     width_q  <= cfg_data_i[DimW-1:0];
        CfgThreshold: thr_q    <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (height_q == '0) begin
      height_eff = DimW'(1);
    end else if (height_q > DimW'(MaxRows)) begin
      height_eff = DimW'(MaxRows);
    end else begin
      height_eff = height_q;
    end
    width_eff = (width_q > DimW'(MaxCols)) ? DimW'(MaxCols) : width_q;
    for (int i = 0; i < MaxCols; i++) begin
      col_mask[i] = DimW'(i) < width_eff;
    end
  end

  bwmf_row_seq u_row_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .row_pixels_i (row_pixels_i),
    .height_i     (height_eff),
    .col_mask_i   (col_mask),
    .job_valid_o  (job_valid),
    .job_o        (job),
    .job_ready_i  (job_ready)
  );

  bwmf_vote u_vote (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (job),
    .job_ready_o    (job_ready),
    .col_mask_i     (col_mask),
    .thr_i          (thr_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .filtered_row_o (filtered_row_o),
    .row_number_o   (row_number_o),
    .frame_done_o   (frame_done_o)
  );

endmodule
